/* sv/kct_pkg.sv */
package kct_pkg;

  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned PROC_W   = 22;
  localparam int unsigned POS_W    = 20;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned GEN_W    = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OIDX_W   = 7;

  localparam logic [TICK_W-1:0] TTL_RESET = 32'd30000;

  localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle_key;
    logic [PROC_W-1:0]   process_id;
    logic [GEN_W-1:0]    generation;
    logic [TICK_W-1:0]   now_tick;
    logic [POS_W-1:0]    new_position;
  } kct_in_t;

  typedef struct packed {
    logic [OIDX_W-1:0] slot_index;
    logic [POS_W-1:0]  position;
    logic              was_hit;
  } kct_out_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PROC_W-1:0]   process;
    logic [POS_W-1:0]    position;
    logic [TICK_W-1:0]   last_used;
    logic [GEN_W-1:0]    generation;
  } kct_slot_t;

  localparam int unsigned SLOT_W = $bits(kct_slot_t);

endpackage

/* sv/keyed_cursor_table_lru_ttl_core.sv */
// Cursor table of SLOT_COUNT slots held in one RAM with a separate read and write port. After
// reset the block runs a clearing pass over all SLOT_COUNT slots with busy high; an invalidate
// beat runs the same pass and then strobes its result. A locate or write beat scans every slot
// once through the RAM read port (one slot per cycle), then writes the chosen slot back; its
// result strobes in the same cycle that busy falls. An unknown mode strobes its result in the
// cycle after the beat. The result is shown for one cycle only and the receiver cannot stall
// it; the config port is always ready.
module keyed_cursor_table_lru_ttl_core
  import kct_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  kct_in_t     in_i,
  output logic        out_valid_o,
  output kct_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic              issue_done_q, issue_done_d;
  logic              rv_q, rv_d;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic              ack_q, ack_d;
  kct_in_t           in_q, in_d;
  logic [TICK_W-1:0] tn_q, tn_d;
  logic              hit_found_q, hit_found_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [POS_W-1:0]  hit_pos_q, hit_pos_d;
  logic [GEN_W-1:0]  hit_gen_q, hit_gen_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [TICK_W-1:0] old_tick_q, old_tick_d;
  logic              out_valid_q, out_valid_d;
  kct_out_t          out_q, out_d;
  logic [TICK_W-1:0] ttl_q, ttl_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  kct_slot_t         ram_wdata;
  logic              ram_re;
  kct_slot_t         ram_rdata;

  logic              accept;
  logic              hit_now;
  logic              free_now;
  logic [TICK_W-1:0] exp_diff;
  logic [IDX_W-1:0]  sel_idx;
  logic [POS_W-1:0]  pos_after;

  kct_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign exp_diff = ram_rdata.last_used + tn_q;
  assign hit_now  = (ram_rdata.handle != '0) && (ram_rdata.handle == in_q.handle_key) &&
                    (ram_rdata.process == in_q.process_id);
  assign free_now = (ram_rdata.handle == '0) || exp_diff[TICK_W-1];

  always_comb begin
    if (hit_found_q) begin
      sel_idx = hit_idx_q;
    end else if (free_found_q) begin
      sel_idx = free_idx_q;
    end else begin
      sel_idx = old_idx_q;
    end
    if (hit_found_q && (hit_gen_q == in_q.generation)) begin
      pos_after = hit_pos_q;
    end else begin
      pos_after = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    rv_d         = 1'b0;
    ridx_d       = addr_q;
    ack_d        = ack_q;
    in_d         = in_q;
    tn_d         = tn_q;
    hit_found_d  = hit_found_q;
    hit_idx_d    = hit_idx_q;
    hit_pos_d    = hit_pos_q;
    hit_gen_d    = hit_gen_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    old_idx_d    = old_idx_q;
    old_tick_d   = old_tick_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;
    ttl_d        = ttl_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;

    if (cfg_valid_i) begin
      ttl_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_d         = in_i;
          tn_d         = ttl_q - in_i.now_tick;
          addr_d       = '0;
          issue_done_d = 1'b0;
          hit_found_d  = 1'b0;
          free_found_d = 1'b0;
          if (in_i.mode == MODE_LOCATE || in_i.mode == MODE_WRITE) begin
            state_d = ST_SCAN;
          end else if (in_i.mode == MODE_FLUSH) begin
            state_d = ST_CLEAR;
            ack_d   = 1'b1;
          end else begin
            out_valid_d = 1'b1;
            out_d       = '0;
          end
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == LAST_IDX) begin
          state_d     = ST_IDLE;
          addr_d      = '0;
          ack_d       = 1'b0;
          out_valid_d = ack_q;
          out_d       = '0;
        end
      end
      ST_SCAN: begin
        if (!issue_done_q) begin
          ram_re = 1'b1;
          rv_d   = 1'b1;
          addr_d = addr_q + 1'b1;
          if (addr_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end
        end
        if (rv_q) begin
          if (!hit_found_q && hit_now) begin
            hit_found_d = 1'b1;
            hit_idx_d   = ridx_q;
            hit_pos_d   = ram_rdata.position;
            hit_gen_d   = ram_rdata.generation;
          end
          if (!free_found_q && free_now) begin
            free_found_d = 1'b1;
            free_idx_d   = ridx_q;
          end
          if (ridx_q == '0 || ram_rdata.last_used < old_tick_q) begin
            old_idx_d  = ridx_q;
            old_tick_d = ram_rdata.last_used;
          end
          if (ridx_q == LAST_IDX) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        ram_we               = 1'b1;
        ram_waddr            = sel_idx;
        ram_wdata.handle     = in_q.handle_key;
        ram_wdata.process    = in_q.process_id;
        ram_wdata.position   = (in_q.mode == MODE_WRITE) ? in_q.new_position : pos_after;
        ram_wdata.last_used  = in_q.now_tick;
        ram_wdata.generation = in_q.generation;
        out_valid_d          = 1'b1;
        out_d.slot_index     = OIDX_W'(sel_idx);
        out_d.position       = pos_after;
        out_d.was_hit        = hit_found_q;
        addr_d               = '0;
        state_d              = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rv_q         <= 1'b0;
      ack_q        <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ttl_q        <= TTL_RESET;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rv_q         <= rv_d;
      ack_q        <= ack_d;
      hit_found_q  <= hit_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      ttl_q        <= ttl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    in_q       <= in_d;
    tn_q       <= tn_d;
    hit_idx_q  <= hit_idx_d;
    hit_pos_q  <= hit_pos_d;
    hit_gen_q  <= hit_gen_d;
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_tick_q <= old_tick_d;
    out_q      <= out_d;
  end

endmodule

/* sv/kct_ram.sv */
module kct_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 170,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* test/tb_keyed_cursor_table_lru_ttl_core.sv */
module tb_keyed_cursor_table_lru_ttl_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kct_pkg::*;

  localparam int unsigned SLOTS = 128;
  localparam int unsigned POOL = 160;
  localparam int unsigned HOT = 40;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  kct_in_t     cmd_q = '0;
  logic        out_valid_o;
  kct_out_t    out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  keyed_cursor_table_lru_ttl_core #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (cmd_q),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [HANDLE_W-1:0] cur_handle [SLOTS];
  logic [PROC_W-1:0]   cur_proc   [SLOTS];
  logic [POS_W-1:0]    cur_pos    [SLOTS];
  logic [TICK_W-1:0]   cur_tick   [SLOTS];
  logic [GEN_W-1:0]    cur_gen    [SLOTS];
  logic [TICK_W-1:0]   ttl_model = TTL_RESET;

  kct_in_t  pending_cmds[$];
  kct_out_t expected_lookups[$];

  logic [HANDLE_W-1:0] pool_handle [POOL];
  logic [PROC_W-1:0]   pool_proc   [POOL];

  int  gap_left = 0;
  bit  item_loaded = 1'b0;
  bit  steady = 1'b0;
  int  fail_count = 0;
  int  accepted_count = 0;
  int  hit_count = 0;
  int  flush_count = 0;
  int  ttl_settings = 1;

  initial begin
    foreach (cur_handle[i]) begin
      cur_handle[i] = '0;
      cur_proc[i] = '0;
      cur_pos[i] = '0;
      cur_tick[i] = '0;
      cur_gen[i] = '0;
    end
  end

  function automatic kct_out_t lookup_cursor(input kct_in_t c);
    kct_out_t res;
    int slot;
    int oldest;
    logic [TICK_W-1:0] slack;
    res = '0;
    slot = -1;
    oldest = 0;
    if (c.mode == MODE_FLUSH) begin
      foreach (cur_handle[i]) cur_handle[i] = '0;
      return res;
    end
    if (c.mode != MODE_LOCATE && c.mode != MODE_WRITE) return res;
    for (int i = 0; i < SLOTS; i++) begin
      if (cur_handle[i] != '0 && cur_handle[i] == c.handle_key &&
          cur_proc[i] == c.process_id) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      res.was_hit = 1'b1;
      if (cur_gen[slot] != c.generation) begin
        cur_pos[slot] = '0;
        cur_gen[slot] = c.generation;
      end
      cur_tick[slot] = c.now_tick;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        slack = cur_tick[i] + ttl_model - c.now_tick;
        if (cur_handle[i] == '0 || slack[TICK_W-1]) begin
          slot = i;
          break;
        end
        if (cur_tick[i] < cur_tick[oldest]) oldest = i;
      end
      if (slot < 0) slot = oldest;
      cur_handle[slot] = c.handle_key;
      cur_proc[slot] = c.process_id;
      cur_pos[slot] = '0;
      cur_tick[slot] = c.now_tick;
      cur_gen[slot] = c.generation;
    end
    res.slot_index = slot[OIDX_W-1:0];
    res.position = cur_pos[slot];
    if (c.mode == MODE_WRITE) cur_pos[slot] = c.new_position;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kct_out_t want;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_q <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        want = lookup_cursor(cmd_q);
        expected_lookups.push_back(want);
        accepted_count++;
        hit_count += int'(want.was_hit);
        if (cmd_q.mode == MODE_FLUSH) flush_count++;
        item_loaded = 1'b0;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (!steady && $urandom_range(0, 19) == 0) begin
        gap_left <= $urandom_range(0, 5);
        start <= 1'b0;
      end else begin
        if (!item_loaded && pending_cmds.size() != 0) begin
          cmd_q <= pending_cmds.pop_front();
          item_loaded = 1'b1;
        end
        start <= item_loaded;
      end
    end
  end

  always @(posedge clk_i) begin
    kct_out_t want;
    if (rst_ni && out_valid_o === 1'b1) begin
      if (expected_lookups.size() == 0) begin
        $error("result beat with nothing pending: slot_index %0d position %0h was_hit %0b",
               out_o.slot_index, out_o.position, out_o.was_hit);
        fail_count++;
      end else begin
        want = expected_lookups.pop_front();
        if (out_o.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, out_o.slot_index);
          fail_count++;
        end
        if (out_o.position !== want.position) begin
          $error("position: expected %0h, got %0h", want.position, out_o.position);
          fail_count++;
        end
        if (out_o.was_hit !== want.was_hit) begin
          $error("was_hit: expected %0b, got %0b", want.was_hit, out_o.was_hit);
          fail_count++;
        end
      end
    end
  end

  function automatic kct_in_t make_cmd(input logic [MODE_W-1:0] mode,
                                       input logic [HANDLE_W-1:0] handle,
                                       input logic [PROC_W-1:0] proc,
                                       input logic [GEN_W-1:0] gen,
                                       input logic [TICK_W-1:0] now,
                                       input logic [POS_W-1:0] npos);
    kct_in_t c;
    c.mode = mode;
    c.handle_key = handle;
    c.process_id = proc;
    c.generation = gen;
    c.now_tick = now;
    c.new_position = npos;
    return c;
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || item_loaded || expected_lookups.size() != 0 || busy);
  endtask

  task automatic set_ttl(input logic [31:0] val);
    wait_drained();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    ttl_model = val;
    ttl_settings++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random(input int count, input logic [31:0] tick0, input int tick_step);
    logic [TICK_W-1:0] tick;
    logic [GEN_W-1:0]  gens [3];
    kct_in_t c;
    int k;
    int pick;
    tick = tick0;
    foreach (pool_handle[i]) begin
      pool_handle[i] = {$urandom, $urandom};
      pool_proc[i] = PROC_W'($urandom);
    end
    foreach (gens[i]) gens[i] = $urandom;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        c.mode = MODE_W'($urandom_range(0, 3));
        c.handle_key = {$urandom, $urandom};
        c.process_id = PROC_W'($urandom);
        c.generation = $urandom;
        c.now_tick = $urandom;
        c.new_position = POS_W'($urandom);
      end else begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POOL - 1) : $urandom_range(0, HOT - 1);
        tick += $urandom_range(0, tick_step);
        if ($urandom_range(0, 49) == 0) tick += $urandom;
        pick = $urandom_range(0, 99);
        c.mode = (pick < 60) ? MODE_LOCATE : (pick < 96) ? MODE_WRITE :
                 (pick < 98) ? MODE_FLUSH : MODE_UNUSED;
        c.handle_key = pool_handle[k];
        c.process_id = pool_proc[k];
        c.generation = gens[$urandom_range(0, 2)];
        c.now_tick = tick;
        c.new_position = POS_W'($urandom);
      end
      pending_cmds.push_back(c);
    end
  endtask

  initial begin
    logic [HANDLE_W-1:0] h1;
    h1 = 64'h0123_4567_89AB_CDEF;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i);
    while (busy !== 1'b0);

    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'd100, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'd200, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_WRITE, h1, 22'h3FFFFF, 32'h0, 32'd300, 20'hFFFFF));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'd400, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'hFFFF_FFFF, 32'd500, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, 64'h0, 22'h0, 32'h0, 32'd600, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_WRITE, 64'h0, 22'h0, 32'h0, 32'd700, 20'h12345));
    pending_cmds.push_back(make_cmd(MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 22'h0, 32'hAAAA_AAAA,
                                    32'd800, 20'hAAAAA));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h155555, 32'h0, 32'd850, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_WRITE, 64'h5555_5555_5555_5555, 22'h2AAAAA,
                                    32'h5555_5555, 32'd900, 20'h55555));
    pending_cmds.push_back(make_cmd(MODE_UNUSED, h1, 22'h3FFFFF, 32'h0, 32'd1000, 20'hFFFFF));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, 64'hAAAA_AAAA_AAAA_AAAA, 22'h0, 32'h0,
                                    32'h0010_0000, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'h0010_0000, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_FLUSH, h1, 22'h3FFFFF, 32'h0, 32'h0010_0000, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'hFFFF_FFFF, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_WRITE, h1, 22'h3FFFFF, 32'h0, 32'd5, 20'h12345));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, h1, 22'h3FFFFF, 32'h0, 32'd6, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_LOCATE, 64'hAAAA_AAAA_AAAA_AAAA, 22'h0, 32'h0,
                                    32'd7, 20'h0));
    pending_cmds.push_back(make_cmd(MODE_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 22'h3FFFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF));
    pending_cmds.push_back(make_cmd(MODE_UNUSED, 64'h0, 22'h0, 32'h0, 32'h0, 20'h0));

    queue_random(300, 32'h0, 400);
    set_ttl(32'h0);
    queue_random(250, 32'h0000_1000, 3);
    set_ttl(32'hFFFF_FFFF);
    queue_random(250, 32'hFFFF_F000, 50);
    set_ttl(32'h7FFF_FFFF);
    queue_random(450, 32'hFFFF_0000, 1000);
    set_ttl(32'd2000);
    steady = 1'b1;
    queue_random(500, 32'h8000_0000, 40);

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk_i);
    @(negedge clk_i);
    $display("covered %0d commands under %0d ttl settings: %0d hits, %0d flushes",
             accepted_count, ttl_settings, hit_count, flush_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
